// ----- src/hmq_pkg.sv -----
// ============================================================================
// hmq_pkg
// Shared types and constants for the binary min-heap queue unit.
// ============================================================================
`default_nettype none

package hmq_pkg;

    // Heap capacity and derived widths
    localparam int CAPACITY = 1024;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int IDX_W    = ADDR_W + 2;
    localparam int VAL_W    = 32;
    localparam int TOTAL_W  = 11;

    // Result status codes
    localparam logic [1:0] ST_INSERTED = 2'd0;
    localparam logic [1:0] ST_POPPED   = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_EMPTY    = 2'd3;

    // Operation codes
    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_POP    = 1'b1;

    typedef struct packed {
        logic                    action;
        logic signed [VAL_W-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic        [1:0]         status;
        logic signed [VAL_W-1:0]   popped_value;
        logic        [TOTAL_W-1:0] entry_total;
    } t_out_item;

endpackage

`default_nettype wire

// ----- src/hmq_ram.sv -----
// ============================================================================
// hmq_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ============================================================================
`default_nettype none

module hmq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

`default_nettype wire

// ----- src/binary_min_heap_queue_unit.sv -----
// ============================================================================
// binary_min_heap_queue_unit
// Priority queue of signed 32-bit values kept as a binary min-heap in RAM.
// ============================================================================
// Each input transaction either inserts a value (action 0) or pops the
// minimum (action 1) and yields exactly one result transaction carrying the
// status, the popped value (zero unless a pop succeeded) and the entry count
// afterward. Items are handled one at a time and the heap lives in a single
// RAM with one read and one write port. An insert moves each strictly larger
// parent down one level and then writes the new value in place. A pop reads
// the root, fetches the last entry and sinks it from the root; the sift-down
// needs two RAM reads per level through the single read port. A pop that
// leaves zero or one entry does not sift down, and a full insert or an empty
// pop goes straight to the result. The next transaction is taken once the
// current one has been placed in the output register, even if that result
// is still waiting to be taken.
// ============================================================================
`default_nettype none

module binary_min_heap_queue_unit
    import hmq_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_ready,
    input  wire t_in_item  i_in_data,
    output logic           o_out_valid,
    input  wire logic      i_out_ready,
    output t_out_item      o_out_data
);

    // State codes
    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_UP_CMP   = 3'd1;
    localparam logic [2:0] S_POP_LAST = 3'd2;
    localparam logic [2:0] S_POP_V    = 3'd3;
    localparam logic [2:0] S_DN_RDR   = 3'd4;
    localparam logic [2:0] S_DN_CMP   = 3'd5;
    localparam logic [2:0] S_WRV      = 3'd6;
    localparam logic [2:0] S_DONE     = 3'd7;

    logic [2:0]              r_state,     n_state;
    logic [CNT_W-1:0]        r_count,     n_count;
    logic [ADDR_W-1:0]       r_pos,       n_pos;
    logic signed [VAL_W-1:0] r_val,       n_val;
    logic signed [VAL_W-1:0] r_left,      n_left;
    logic [1:0]              r_status,    n_status;
    logic signed [VAL_W-1:0] r_popped,    n_popped;
    logic                    r_out_valid, n_out_valid;
    t_out_item               r_out,       n_out;

    // RAM ports
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [VAL_W-1:0]  wr_data;
    logic [ADDR_W-1:0] rd_addr;
    logic [VAL_W-1:0]  rd_data;
    logic signed [VAL_W-1:0] rd_val;

    // Index helpers
    logic [ADDR_W-1:0] cnt_pos;
    logic [ADDR_W-1:0] cnt_pm1;
    logic [ADDR_W-1:0] cnt_parent;
    logic [ADDR_W-1:0] pos_pm1;
    logic [ADDR_W-1:0] pos_parent;
    logic [ADDR_W-1:0] par_pm1;
    logic [ADDR_W-1:0] par_parent;
    logic [IDX_W-1:0]  left_idx;
    logic [IDX_W-1:0]  right_idx;
    logic [IDX_W-1:0]  cnt_idx;
    logic              right_ok;
    logic              pick_right;
    logic [ADDR_W-1:0] pick_pos;
    logic signed [VAL_W-1:0] pick_val;
    logic [IDX_W-1:0]  next_left;
    logic              accept;

    hmq_ram #(
        .WIDTH (VAL_W),
        .DEPTH (CAPACITY)
    ) u_heap_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign rd_val = $signed(rd_data);
    assign accept = i_in_valid && o_in_ready;

    // Parent and child indexes
    always_comb begin
        cnt_pos    = r_count[ADDR_W-1:0];
        cnt_pm1    = cnt_pos - ADDR_W'(1);
        cnt_parent = {1'b0, cnt_pm1[ADDR_W-1:1]};
        pos_pm1    = r_pos - ADDR_W'(1);
        pos_parent = {1'b0, pos_pm1[ADDR_W-1:1]};
        par_pm1    = pos_parent - ADDR_W'(1);
        par_parent = {1'b0, par_pm1[ADDR_W-1:1]};
        left_idx   = {1'b0, r_pos, 1'b1};
        right_idx  = {1'b0, r_pos, 1'b0} + IDX_W'(2);
        cnt_idx    = IDX_W'(r_count);
        right_ok   = right_idx < cnt_idx;
        pick_right = right_ok && (r_left > rd_val);
        pick_pos   = pick_right ? right_idx[ADDR_W-1:0] : left_idx[ADDR_W-1:0];
        pick_val   = pick_right ? rd_val : r_left;
        next_left  = {1'b0, pick_pos, 1'b1};
    end

    // Sequencer: read, compare, write back
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_pos       = r_pos;
        n_val       = r_val;
        n_left      = r_left;
        n_status    = r_status;
        n_popped    = r_popped;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        wr_en       = 1'b0;
        wr_addr     = r_pos;
        wr_data     = r_val;
        rd_addr     = '0;

        // Drop the result once taken
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_val    = i_in_data.value;
                    n_popped = '0;
                    if (i_in_data.action == ACT_INSERT) begin
                        if (r_count >= CNT_W'(CAPACITY)) begin
                            n_status = ST_FULL;
                            n_state  = S_DONE;
                        end else begin
                            n_status = ST_INSERTED;
                            n_count  = r_count + CNT_W'(1);
                            n_pos    = cnt_pos;
                            rd_addr  = cnt_parent;
                            n_state  = (cnt_pos == '0) ? S_WRV : S_UP_CMP;
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_status = ST_EMPTY;
                            n_state  = S_DONE;
                        end else begin
                            n_status = ST_POPPED;
                            rd_addr  = '0;
                            n_state  = S_POP_LAST;
                        end
                    end
                end
            end
            S_UP_CMP: begin
                // Move the parent down while it is strictly larger
                if (r_val < rd_val) begin
                    wr_en   = 1'b1;
                    wr_data = rd_data;
                    n_pos   = pos_parent;
                    rd_addr = par_parent;
                    n_state = (pos_parent == '0) ? S_WRV : S_UP_CMP;
                end else begin
                    wr_en   = 1'b1;
                    n_state = S_DONE;
                end
            end
            S_POP_LAST: begin
                // Capture the root, fetch the last entry
                n_popped = rd_val;
                rd_addr  = cnt_pm1;
                n_count  = r_count - CNT_W'(1);
            end
            S_POP_V: begin
                n_val = rd_val;
                if (r_count == '0) begin
                    n_state = S_DONE;
                end else if (r_count == CNT_W'(1)) begin
                    wr_en   = 1'b1;
                    wr_addr = '0;
                    wr_data = rd_data;
                    n_state = S_DONE;
                end else begin
                    n_pos   = '0;
                    rd_addr = ADDR_W'(1);
                    n_state = S_DN_RDR;
                end
            end
            S_DN_RDR: begin
                // Hold the left child, fetch the right one
                n_left  = rd_val;
                rd_addr = right_idx[ADDR_W-1:0];
                n_state = S_DN_CMP;
            end
            S_DN_CMP: begin
                // Move the smaller child up while the entry is strictly larger
                if (r_val > pick_val) begin
                    wr_en   = 1'b1;
                    wr_data = pick_val;
                    n_pos   = pick_pos;
                    rd_addr = next_left[ADDR_W-1:0];
                    n_state = (next_left < cnt_idx) ? S_DN_RDR : S_WRV;
                end else begin
                    wr_en   = 1'b1;
                    n_state = S_DONE;
                end
            end
            S_WRV: begin
                wr_en   = 1'b1;
                n_state = S_DONE;
            end
            S_DONE: begin
                // Load the output register when it is free
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid          = 1'b1;
                    n_out.status         = r_status;
                    n_out.popped_value   = r_popped;
                    n_out.entry_total    = TOTAL_W'(r_count);
                    n_state              = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // POP_LAST always advances
        if (r_state == S_POP_LAST) begin
            n_state = S_POP_V;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_pos    <= n_pos;
        r_val    <= n_val;
        r_left   <= n_left;
        r_status <= n_status;
        r_popped <= n_popped;
        r_out    <= n_out;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire
